// ----- src/u2u8_pkg.sv -----
// Package with shared types and constants of the UTF-16 to UTF-8 encoder.
package u2u8_pkg;

    // Depth of the job queue between front and back; must be a power of two.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 21;
    localparam int unsigned IDX_W   = 3;

    // Top five bits shared by every surrogate (D800..DFFF).
    localparam logic [4:0] SURROGATE_TAG = 5'b11011;
    localparam logic [VALUE_W-1:0] SUPPLEMENTARY_BASE = 21'h10000;

    // Replacement character U+FFFD in UTF-8.
    localparam logic [BYTE_W-1:0] REPL_BYTE0 = 8'hEF;
    localparam logic [BYTE_W-1:0] REPL_BYTE1 = 8'hBF;
    localparam logic [BYTE_W-1:0] REPL_BYTE2 = 8'hBD;
    localparam logic [IDX_W-1:0]  REPL_LEN   = 3'd3;

    // What the back end has to emit for one code point.
    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_ONE   = 3'd1,
        KIND_TWO   = 3'd2,
        KIND_THREE = 3'd3,
        KIND_FOUR  = 3'd4,
        KIND_REPL  = 3'd5
    } kind_t;

    typedef struct packed {
        logic               repl_prefix;
        kind_t              kind;
        logic [VALUE_W-1:0] value;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } push_t;

endpackage

// ----- src/u2u8_unit_if.sv -----
// Stream interface carrying one UTF-16 code unit per beat.
interface u2u8_unit_if;
    logic                          valid;
    logic                          ready;
    logic [u2u8_pkg::UNIT_W-1:0]   code_unit;
    logic                          end_of_string;

    modport source (output valid, output code_unit, output end_of_string, input ready);
    modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

// ----- src/u2u8_byte_if.sv -----
// Stream interface carrying one UTF-8 byte per beat.
interface u2u8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ----- src/utf16_to_utf8_encoder_core.sv -----
// Top level of the UTF-16 to UTF-8 encoder: front end, job queue and byte emitter.
//
//   Channel  Dir  Beat content                         Handshake
//   in       in   code_unit[15:0], end_of_string       valid/ready
//   out      out  out_byte[7:0], run_last              valid/ready
//
// The front end takes one code unit per cycle while the job queue has room and
// turns it into a job in the same cycle; a high surrogate waiting for its partner
// produces no job. The back end emits one byte per cycle while the output is ready,
// and a unit yields 0 to 6 bytes; the byte emitter sets the sustained rate.
// Reset clears the held surrogate, the queue and the output valid flag.
// A stall on the output side fills the two-entry queue before input ready drops.
module utf16_to_utf8_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    u2u8_unit_if.sink   in,
    u2u8_byte_if.source out
);

    u2u8_pkg::push_t push;
    u2u8_pkg::job_t  head;
    logic            queue_full;
    logic            head_valid;
    logic            pop;

    // Front end: surrogate pairing and classification of each beat.
    u2u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in         (in),
        .queue_full (queue_full),
        .push       (push)
    );

    // Queue lets the front keep taking units while the back drains a long run.
    u2u8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end: serializes each job into UTF-8 bytes, marking the last one.
    u2u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out        (out)
    );

endmodule

// ----- src/u2u8_front.sv -----
// Front end: accepts code units, pairs surrogates and classifies each unit into a job.
module u2u8_front (
    input  logic            clk,
    input  logic            rst_n,
    u2u8_unit_if.sink       in,
    input  logic            queue_full,
    output u2u8_pkg::push_t push
);

    logic       held_valid_reg;
    logic       held_valid_next;
    logic [9:0] held_bits_reg;
    logic [9:0] held_bits_next;

    logic            accept;
    logic            is_surrogate;
    logic            is_high;
    u2u8_pkg::job_t  job;

    assign in.ready     = !queue_full;
    assign accept       = in.valid && in.ready;
    assign is_surrogate = (in.code_unit[15:11] == u2u8_pkg::SURROGATE_TAG);
    assign is_high      = is_surrogate && !in.code_unit[10];

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        job.repl_prefix = 1'b0;
        job.kind        = u2u8_pkg::KIND_NONE;
        job.value       = {5'd0, in.code_unit};
        if (accept)
        begin
            held_valid_next = 1'b0;
            held_bits_next  = 10'd0;
            if (held_valid_reg && is_surrogate && in.code_unit[10])
            begin
                job.kind  = u2u8_pkg::KIND_FOUR;
                job.value = {1'b0, held_bits_reg, in.code_unit[9:0]}
                            + u2u8_pkg::SUPPLEMENTARY_BASE;
            end
            else
            begin
                job.repl_prefix = held_valid_reg;
                priority if (in.code_unit[15:7] == 9'd0)
                    job.kind = u2u8_pkg::KIND_ONE;
                else if (in.code_unit[15:11] == 5'd0)
                    job.kind = u2u8_pkg::KIND_TWO;
                else if (!is_surrogate)
                    job.kind = u2u8_pkg::KIND_THREE;
                else if (is_high && !in.end_of_string)
                begin
                    job.kind        = u2u8_pkg::KIND_NONE;
                    held_valid_next = 1'b1;
                    held_bits_next  = in.code_unit[9:0];
                end
                else
                    job.kind = u2u8_pkg::KIND_REPL;
            end
        end
    end

    assign push.push = accept && (job.repl_prefix || (job.kind != u2u8_pkg::KIND_NONE));
    assign push.job  = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= 10'd0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule

// ----- src/u2u8_queue.sv -----
// Small job queue that decouples the front end from the byte emitter.
module u2u8_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  u2u8_pkg::push_t push,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output u2u8_pkg::job_t  head
);

    u2u8_pkg::job_t entry_reg [u2u8_pkg::QUEUE_DEPTH];

    logic [u2u8_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [u2u8_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [u2u8_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [u2u8_pkg::QUEUE_CNT_W-1:0] count_next;

    logic do_push;
    logic do_pop;

    assign full       = (count_reg == u2u8_pkg::QUEUE_CNT_W'(u2u8_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/u2u8_back.sv -----
// Back end: walks the bytes of the head job, one per cycle while the output is ready, into an output register.
module u2u8_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  u2u8_pkg::job_t head,
    output logic           pop,
    u2u8_byte_if.source    out
);

    logic [u2u8_pkg::IDX_W-1:0]  idx_reg;
    logic [u2u8_pkg::IDX_W-1:0]  idx_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic [u2u8_pkg::BYTE_W-1:0] byte_reg;
    logic                        last_reg;

    logic [u2u8_pkg::IDX_W-1:0]  prefix_len;
    logic [u2u8_pkg::IDX_W-1:0]  body_len;
    logic [u2u8_pkg::IDX_W-1:0]  total_len;
    logic [u2u8_pkg::IDX_W-1:0]  body_idx;
    logic [u2u8_pkg::BYTE_W-1:0] cur_byte;
    logic                        cur_last;
    logic                        load;

    always_comb
    begin
        prefix_len = head.repl_prefix ? u2u8_pkg::REPL_LEN : '0;
        unique case (head.kind)
            u2u8_pkg::KIND_ONE:   body_len = 3'd1;
            u2u8_pkg::KIND_TWO:   body_len = 3'd2;
            u2u8_pkg::KIND_THREE: body_len = 3'd3;
            u2u8_pkg::KIND_FOUR:  body_len = 3'd4;
            u2u8_pkg::KIND_REPL:  body_len = u2u8_pkg::REPL_LEN;
            default:              body_len = 3'd0;
        endcase
        total_len = prefix_len + body_len;
        body_idx  = idx_reg - prefix_len;
    end

    // Byte selection: replacement prefix first, then the bytes of the code point.
    always_comb
    begin
        cur_byte = 8'd0;
        if (head.repl_prefix && (idx_reg < u2u8_pkg::REPL_LEN))
        begin
            unique case (idx_reg[1:0])
                2'd0:    cur_byte = u2u8_pkg::REPL_BYTE0;
                2'd1:    cur_byte = u2u8_pkg::REPL_BYTE1;
                default: cur_byte = u2u8_pkg::REPL_BYTE2;
            endcase
        end
        else
        begin
            unique case (head.kind)
                u2u8_pkg::KIND_ONE:
                    cur_byte = {1'b0, head.value[6:0]};
                u2u8_pkg::KIND_TWO:
                    cur_byte = (body_idx[1:0] == 2'd0) ? {3'b110, head.value[10:6]}
                                                       : {2'b10, head.value[5:0]};
                u2u8_pkg::KIND_THREE:
                begin
                    unique case (body_idx[1:0])
                        2'd0:    cur_byte = {4'b1110, head.value[15:12]};
                        2'd1:    cur_byte = {2'b10, head.value[11:6]};
                        default: cur_byte = {2'b10, head.value[5:0]};
                    endcase
                end
                u2u8_pkg::KIND_FOUR:
                begin
                    unique case (body_idx[1:0])
                        2'd0:    cur_byte = {5'b11110, head.value[20:18]};
                        2'd1:    cur_byte = {2'b10, head.value[17:12]};
                        2'd2:    cur_byte = {2'b10, head.value[11:6]};
                        default: cur_byte = {2'b10, head.value[5:0]};
                    endcase
                end
                u2u8_pkg::KIND_REPL:
                begin
                    unique case (body_idx[1:0])
                        2'd0:    cur_byte = u2u8_pkg::REPL_BYTE0;
                        2'd1:    cur_byte = u2u8_pkg::REPL_BYTE1;
                        default: cur_byte = u2u8_pkg::REPL_BYTE2;
                    endcase
                end
                default:
                    cur_byte = 8'd0;
            endcase
        end
    end

    assign cur_last = (idx_reg == total_len - 1'b1);
    assign load     = head_valid && (!valid_reg || out.ready);
    assign pop      = load && cur_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = cur_last ? '0 : idx_reg + 1'b1;
        end
        else if (out.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= cur_byte;
            last_reg <= cur_last;
        end
    end

    assign out.valid    = valid_reg;
    assign out.out_byte = byte_reg;
    assign out.run_last = last_reg;

endmodule

// ----- sim/u2u8_checker.sv -----
// Checker for the UTF-16 to UTF-8 encoder: predicts the byte stream and compares each beat.
module u2u8_checker (
    input  logic  clk,
    input  logic  rst_n,
    u2u8_unit_if  unit_mon,
    u2u8_byte_if  byte_mon,
    output int    fail_count,
    output int    bytes_owed,
    output int    bytes_seen
);

    typedef struct packed {
        logic [u2u8_pkg::BYTE_W-1:0] value;
        logic                        last;
    } utf8_beat_t;

    utf8_beat_t          owed_q[$];
    logic [9:0]          held_bits;
    logic                held;
    int                  mismatches;
    int                  seen;

    task automatic add_byte(input logic [u2u8_pkg::BYTE_W-1:0] b);
        utf8_beat_t beat;
        beat.value = b;
        beat.last  = 1'b0;
        owed_q.insert(owed_q.size(), beat);
    endtask

    task automatic add_replacement();
        add_byte(u2u8_pkg::REPL_BYTE0);
        add_byte(u2u8_pkg::REPL_BYTE1);
        add_byte(u2u8_pkg::REPL_BYTE2);
    endtask

    // Appends the bytes that one accepted code unit produces and updates the
    // held high surrogate.
    task automatic encode_unit(input logic [15:0] cu, input logic eos);
        int            start_size;
        logic [20:0]   cp;
        logic          paired;
        start_size = owed_q.size();
        paired     = 1'b0;
        if (held)
        begin
            held = 1'b0;
            if (cu[15:10] == 6'b110111)
            begin
                cp = {held_bits, cu[9:0]} + 21'h10000;
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
                paired = 1'b1;
            end
            else
            begin
                add_replacement();
            end
            held_bits = '0;
        end
        if (!paired)
        begin
            if (cu < 16'h0080)
            begin
                add_byte(cu[7:0]);
            end
            else if (cu < 16'h0800)
            begin
                add_byte({3'b110, cu[10:6]});
                add_byte({2'b10, cu[5:0]});
            end
            else if (cu < 16'hD800 || cu >= 16'hE000)
            begin
                add_byte({4'b1110, cu[15:12]});
                add_byte({2'b10, cu[11:6]});
                add_byte({2'b10, cu[5:0]});
            end
            else if (cu <= 16'hDBFF && !eos)
            begin
                held_bits = cu[9:0];
                held      = 1'b1;
            end
            else
            begin
                add_replacement();
            end
        end
        if (owed_q.size() > start_size)
        begin
            owed_q[owed_q.size() - 1].last = 1'b1;
        end
    endtask

    // Inputs are handled before outputs so that a beat accepted on both sides
    // at the same edge still finds its expectation.
    always @(posedge clk or negedge rst_n)
    begin
        utf8_beat_t exp_beat;
        if (!rst_n)
        begin
            held      = 1'b0;
            held_bits = '0;
            owed_q.delete();
        end
        else
        begin
            if (unit_mon.valid && unit_mon.ready)
            begin
                encode_unit(unit_mon.code_unit, unit_mon.end_of_string);
            end
            if (byte_mon.valid && byte_mon.ready)
            begin
                seen++;
                if (owed_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                             $time, byte_mon.out_byte, byte_mon.run_last);
                end
                else
                begin
                    exp_beat = owed_q.pop_front();
                    if (byte_mon.out_byte !== exp_beat.value)
                    begin
                        mismatches++;
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, exp_beat.value, byte_mon.out_byte);
                    end
                    if (byte_mon.run_last !== exp_beat.last)
                    begin
                        mismatches++;
                        $display("%0t: run_last mismatch, expected %0b, actual %0b",
                                 $time, exp_beat.last, byte_mon.run_last);
                    end
                end
            end
        end
        fail_count <= mismatches;
        bytes_owed <= owed_q.size();
        bytes_seen <= seen;
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the UTF-16 to UTF-8 encoder: stimulus, back-pressure, watchdog and verdict.
module tb_top;

    // Cycles without any accepted beat on either channel before the run is
    // declared hung. A correct run never gets close to this.
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_UNITS  = 86;
    // Cycles to keep watching after the last expected byte, so that any
    // stray extra byte from the encoder is still caught.
    localparam int DRAIN_CYCLES  = 20;

    logic clk;
    logic rst_n;
    // When low, neither the sender nor the receiver inserts idle cycles.
    logic idle_enable;

    int   units_sent;
    int   stall_cycles;
    int   fail_count;
    int   bytes_owed;
    int   bytes_seen;

    u2u8_unit_if unit_ch();
    u2u8_byte_if byte_ch();

    utf16_to_utf8_encoder_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (unit_ch),
        .out   (byte_ch)
    );

    u2u8_checker utf8_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_mon   (unit_ch),
        .byte_mon   (byte_ch),
        .fail_count (fail_count),
        .bytes_owed (bytes_owed),
        .bytes_seen (bytes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The receiver drops ready on about one cycle in five while idling is
    // enabled, otherwise it takes every byte.
    always @(posedge clk)
    begin
        byte_ch.ready <= !idle_enable || ($urandom_range(99) >= 20);
    end

    // Watchdog: counts consecutive cycles in which no beat moves on either
    // side. Reaching the limit means the encoder or the testbench is stuck.
    always @(posedge clk)
    begin
        if ((unit_ch.valid && unit_ch.ready) || (byte_ch.valid && byte_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offers one code unit and holds it until the encoder takes it. While
    // idling is enabled, valid may drop for a few cycles before the beat.
    task automatic send_unit(input logic [15:0] cu, input logic eos);
        while (idle_enable && $urandom_range(99) < 20)
        begin
            unit_ch.valid <= 1'b0;
            @(posedge clk);
        end
        unit_ch.valid         <= 1'b1;
        unit_ch.code_unit     <= cu;
        unit_ch.end_of_string <= eos;
        @(posedge clk);
        while (!unit_ch.ready)
        begin
            @(posedge clk);
        end
        units_sent++;
    endtask

    // A code unit outside the surrogate range, spread over the 1, 2 and 3
    // byte classes so that all three encodings show up often.
    function automatic logic [15:0] random_scalar();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(16'h0000, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function automatic logic random_eos();
        return ($urandom_range(7) == 0);
    endfunction

    // One random sequence. Most are well formed (plain units and proper
    // surrogate pairs); the rest are lone low surrogates, broken pairs,
    // high surrogates cut off by the end of the string, and raw noise.
    task automatic send_random_sequence();
        logic [15:0] follow;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                send_unit(random_scalar(), random_eos());
            end
            4, 5, 6:
            begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), random_eos());
            end
            7:
            begin
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), random_eos());
            end
            8:
            begin
                // A held high surrogate broken by a non-low unit, which may
                // itself be another high surrogate that starts a new hold.
                follow = $urandom_range(1) ? random_scalar()
                                           : 16'($urandom_range(16'hD800, 16'hDBFF));
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                send_unit(follow, random_eos());
            end
            default:
            begin
                if ($urandom_range(1))
                begin
                    send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b1);
                end
                else
                begin
                    send_unit(16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
                end
            end
        endcase
    endtask

    initial
    begin
        int directed_units;
        int random_start;
        logic paused_once;

        rst_n                 = 1'b0;
        idle_enable           = 1'b1;
        units_sent            = 0;
        paused_once           = 1'b0;
        unit_ch.valid         = 1'b0;
        unit_ch.code_unit     = '0;
        unit_ch.end_of_string = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the edges of each byte-length class.
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // Lowest surrogate pair; end of string on the low half changes nothing.
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b1);
        // Highest surrogate pair, which gives U+10FFFF.
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        // Lone low surrogates at both ends of the low range.
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // High surrogate followed by ASCII: replacement, then the ASCII byte.
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0041, 1'b0);
        // High surrogate followed by another high one, then its low partner.
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDC00, 1'b0);
        // High surrogate at the end of the string is replaced at once.
        send_unit(16'hDBFF, 1'b1);
        // Broken pair followed by a 3-byte unit: the six-byte worst case.
        send_unit(16'hD900, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // Broken pair followed by a 2-byte unit.
        send_unit(16'hDA55, 1'b0);
        send_unit(16'h07FF, 1'b0);

        directed_units = units_sent;
        random_start   = units_sent;

        while (units_sent < random_start + RANDOM_UNITS)
        begin
            // A long stretch in the middle runs with both sides at full rate.
            idle_enable <= !((units_sent >= random_start + 45) &&
                             (units_sent <  random_start + 75));
            // Once, the sender goes quiet until every owed byte has come out.
            if (!paused_once && units_sent >= random_start + 40)
            begin
                paused_once = 1'b1;
                unit_ch.valid <= 1'b0;
                @(posedge clk);
                while (bytes_owed != 0)
                begin
                    @(posedge clk);
                end
            end
            send_random_sequence();
        end

        idle_enable   <= 1'b1;
        unit_ch.valid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d code units (%0d directed, the rest random) and %0d bytes.",
                 units_sent, directed_units, bytes_seen);
        $display("Units spanned 1-3 byte encodings, surrogate pairs and malformed surrogates.");
        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
